// ===== hw/rtl/bsra_pkg.sv =====
package bsra_pkg;

  localparam int ADDR_W     = 64;
  localparam int LEN_W      = 16;
  localparam int FRAG_W     = 5;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_OFFLOAD = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_PASS = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MASK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFLOAD_ENABLE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_READ,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic clear;
  } search_ctrl_t;

  typedef struct packed {
    logic done;
    logic found;
  } search_stat_t;

endpackage

// ===== hw/rtl/bsra_table_mem.sv =====
module bsra_table_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/bsra_slot_search.sv =====
module bsra_slot_search #(
  parameter int SLOT_COUNT = 64,
  parameter int IDX_W      = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bsra_pkg::search_ctrl_t ctrl,
  input  logic [IDX_W-1:0]       clear_idx,
  input  logic [IDX_W-1:0]       query_idx,
  output logic                   query_valid,
  output bsra_pkg::search_stat_t stat,
  output logic [IDX_W-1:0]       found_slot
);
  import bsra_pkg::*;

  localparam int LANES = (SLOT_COUNT - 1 < 8) ? SLOT_COUNT - 1 : 8;
  localparam int SUM_W = IDX_W + 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + LANES + 1);
  localparam logic [SUM_W-1:0] LIMIT = SUM_W'(SLOT_COUNT);
  localparam logic [SUM_W-1:0] WRAP  = SUM_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] TOTAL = CNT_W'(SLOT_COUNT - 1);

  logic [SLOT_COUNT-1:0] valid;
  logic [IDX_W-1:0]      pointer;
  logic [IDX_W-1:0]      cursor;
  logic [CNT_W-1:0]      scanned;
  logic                  busy;
  logic                  done;
  logic                  found;

  logic [SUM_W-1:0] lane_sum [LANES];
  logic [IDX_W-1:0] lane_slot [LANES];
  logic [LANES-1:0] lane_free;
  logic             hit;
  logic [IDX_W-1:0] pick;
  logic [SUM_W-1:0] cursor_sum;
  logic [IDX_W-1:0] cursor_next;
  logic             exhausted;

  // Each lane looks at one slot at or after the cursor, wrapping past the top back to slot 1.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_sum[k] = {1'b0, cursor} + SUM_W'(k);
      if (lane_sum[k] >= LIMIT) begin
        lane_sum[k] = lane_sum[k] - WRAP;
      end
      lane_slot[k] = lane_sum[k][IDX_W-1:0];
      lane_free[k] = !valid[lane_slot[k]] && ((scanned + CNT_W'(k)) < TOTAL);
    end
  end

  always_comb begin
    hit  = 1'b0;
    pick = '0;
    for (int k = LANES - 1; k >= 0; k--) begin
      if (lane_free[k]) begin
        hit  = 1'b1;
        pick = lane_slot[k];
      end
    end
  end

  always_comb begin
    cursor_sum = {1'b0, cursor} + SUM_W'(LANES);
    if (cursor_sum >= LIMIT) begin
      cursor_sum = cursor_sum - WRAP;
    end
    cursor_next = cursor_sum[IDX_W-1:0];
    exhausted   = (scanned + CNT_W'(LANES)) >= TOTAL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      pointer <= IDX_W'(1);
      busy    <= 1'b0;
      done    <= 1'b0;
      found   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy    <= 1'b1;
        cursor  <= pointer;
        scanned <= '0;
      end else if (busy) begin
        if (hit) begin
          busy         <= 1'b0;
          done         <= 1'b1;
          found        <= 1'b1;
          found_slot   <= pick;
          valid[pick]  <= 1'b1;
          pointer      <= pick;
        end else if (exhausted) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          found <= 1'b0;
        end else begin
          cursor  <= cursor_next;
          scanned <= scanned + CNT_W'(LANES);
        end
      end
      if (ctrl.clear) begin
        valid[clear_idx] <= 1'b0;
      end
    end
  end

  assign query_valid = valid[query_idx];
  assign stat.done   = done;
  assign stat.found  = found;

  a_pointer_range: assert property (@(posedge clk) disable iff (rst)
    (pointer != '0) && ({1'b0, pointer} < LIMIT))
    else $error("search pointer left the usable slot range");

  a_found_slot_taken: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (found_slot != '0) && valid[found_slot] && (pointer == found_slot))
    else $error("found slot is reserved or was not marked taken");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> !busy)
    else $error("search started while a search was running");

endmodule

// ===== hw/rtl/buffer_slot_remap_allocator.sv =====
// Channel  Direction  Handshake              Contents
// in       input      in_valid / in_ready    func, head_address, buffer_length,
//                                            fragment_count, packet_length
// out      output     out_valid / out_ready  status, result_address, slot_index,
//                                            offload_length
// cfg      input      cfg_write              cfg_index, cfg_data
//
// One transaction is worked on at a time. Offload lookups, unused codes and allocations that
// do not remap go from the check step straight to the finish step, releases through one
// table memory read, and remapping allocations through the free-slot search, which checks
// up to eight slots a cycle.
// Reset is synchronous; the slot table needs no clearing pass, since a bitmap of taken
// slots guards every read. A result waits in the output register while the next
// transaction is accepted; only the final cycle stalls while that register is still full.
module buffer_slot_remap_allocator #(
  parameter int SLOT_COUNT = 64,
  parameter int SLOT_SHIFT = 11,
  parameter int SLOT_BYTES = 2048
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [bsra_pkg::FUNC_W-1:0]           func,
  input  logic [bsra_pkg::ADDR_W-1:0]           head_address,
  input  logic [bsra_pkg::LEN_W-1:0]            buffer_length,
  input  logic [bsra_pkg::FRAG_W-1:0]           fragment_count,
  input  logic [bsra_pkg::LEN_W-1:0]            packet_length,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bsra_pkg::STATUS_W-1:0]         status,
  output logic [bsra_pkg::ADDR_W-1:0]           result_address,
  output logic [bsra_pkg::SLOT_OUT_W-1:0]       slot_index,
  output logic [bsra_pkg::LEN_W-1:0]            offload_length,
  input  logic                                  cfg_write,
  input  logic [bsra_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bsra_pkg::ADDR_W-1:0]           cfg_data
);
  import bsra_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0] window_base;
  logic [ADDR_W-1:0] window_mask;
  logic              offload_enable;

  logic [FUNC_W-1:0] it_func;
  logic [ADDR_W-1:0] it_head;
  logic [LEN_W-1:0]  it_blen;
  logic [FRAG_W-1:0] it_frags;
  logic [LEN_W-1:0]  it_plen;

  logic             win_hit;
  logic [IDX_W-1:0] win_idx;
  logic             alloc_go;
  logic             rel_ok;

  logic [ADDR_W-1:0] diff;
  logic              win_hit_c;
  logic              alloc_ok_c;
  logic              out_free;
  logic              out_load;

  logic [STATUS_W-1:0]   res_status;
  logic [ADDR_W-1:0]     res_address;
  logic [SLOT_OUT_W-1:0] res_slot;
  logic [LEN_W-1:0]      res_olen;

  search_ctrl_t     sctrl;
  search_stat_t     sstat;
  logic [IDX_W-1:0] found_slot;
  logic             query_valid;

  logic              mem_wr_en;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_data;

  bsra_table_mem #(
    .DEPTH(SLOT_COUNT),
    .WIDTH(ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (found_slot),
    .wr_data (it_head),
    .rd_en   (mem_rd_en),
    .rd_addr (win_idx),
    .rd_data (mem_rd_data)
  );

  bsra_slot_search #(
    .SLOT_COUNT(SLOT_COUNT),
    .IDX_W     (IDX_W)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (sctrl),
    .clear_idx   (win_idx),
    .query_idx   (win_idx),
    .query_valid (query_valid),
    .stat        (sstat),
    .found_slot  (found_slot)
  );

  always_comb begin
    diff       = (it_head >> SLOT_SHIFT) - (window_base >> SLOT_SHIFT);
    win_hit_c  = ((it_head & window_mask) == (window_base & window_mask)) &&
                 (diff < ADDR_W'(SLOT_COUNT));
    alloc_ok_c = offload_enable && (it_frags == '0) &&
                 ({16'd0, it_blen} <= 32'(SLOT_BYTES));
    out_free   = !out_valid || out_ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (it_func == FUNC_ALLOC && alloc_ok_c) begin
          state_next = S_SEARCH;
        end else if (it_func == FUNC_RELEASE) begin
          state_next = S_READ;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SEARCH: begin
        if (sstat.done) begin
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = (state == S_IDLE);
    sctrl.start = (state == S_CHECK) && (it_func == FUNC_ALLOC) && alloc_ok_c;
    out_load    = (state == S_FINISH) && out_free;
    sctrl.clear = out_load && (it_func == FUNC_RELEASE) && rel_ok;
    mem_rd_en   = (state == S_READ);
    mem_wr_en   = out_load && (it_func == FUNC_ALLOC) && alloc_go && sstat.found;
  end

  always_comb begin
    res_status  = STATUS_PASS;
    res_address = it_head;
    res_slot    = '0;
    res_olen    = '0;
    case (it_func)
      FUNC_ALLOC: begin
        if (alloc_go) begin
          if (sstat.found) begin
            res_status  = STATUS_DONE;
            res_address = window_base + (ADDR_W'(found_slot) << SLOT_SHIFT);
            res_slot    = SLOT_OUT_W'(found_slot);
          end else begin
            res_status = STATUS_FULL;
          end
        end
      end
      FUNC_RELEASE: begin
        if (rel_ok) begin
          res_status  = STATUS_DONE;
          res_address = mem_rd_data;
          res_slot    = SLOT_OUT_W'(win_idx);
        end
      end
      FUNC_OFFLOAD: begin
        if (offload_enable && win_hit) begin
          res_status = STATUS_DONE;
          res_slot   = SLOT_OUT_W'(win_idx);
          res_olen   = it_plen;
        end
      end
      default: begin
        res_status = STATUS_PASS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      window_base    <= '0;
      window_mask    <= '0;
      offload_enable <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_WINDOW_BASE:    window_base    <= cfg_data;
          CFG_WINDOW_MASK:    window_mask    <= cfg_data;
          CFG_OFFLOAD_ENABLE: offload_enable <= cfg_data[0];
          default:            ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      it_func  <= func;
      it_head  <= head_address;
      it_blen  <= buffer_length;
      it_frags <= fragment_count;
      it_plen  <= packet_length;
    end
    if (state == S_CHECK) begin
      win_hit  <= win_hit_c;
      win_idx  <= diff[IDX_W-1:0];
      alloc_go <= alloc_ok_c;
    end
    if (state == S_READ) begin
      rel_ok <= (window_base != '0) && win_hit && query_valid;
    end
    if (out_load) begin
      status         <= res_status;
      result_address <= res_address;
      slot_index     <= res_slot;
      offload_length <= res_olen;
    end
  end

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted transaction did not move to the check step");

  a_release_slot_taken: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && (it_func == FUNC_RELEASE) && rel_ok) |-> query_valid)
    else $error("release would free a slot that is not taken");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_PASS || status == STATUS_DONE || status == STATUS_FULL))
    else $error("result carries an unused status code");

  a_full_has_no_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_FULL)) |-> (slot_index == '0) && (offload_length == '0))
    else $error("full result reports a slot or length");

endmodule

// ===== sim/tb_buffer_slot_remap_allocator.sv =====
`timescale 1ns / 1ps

module tb_buffer_slot_remap_allocator;
  import bsra_pkg::*;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_SHIFT = 11;
  localparam int SLOT_BYTES = 2048;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [ADDR_W-1:0] DIR_BASE = 64'h0000_0080_0000_0000;
  localparam logic [ADDR_W-1:0] DIR_MASK = 64'hFFFF_FFFF_FFFE_0000;
  localparam logic [ADDR_W-1:0] TOP_BASE = 64'hFFFF_FFFF_FFFF_F800;
  localparam logic [ADDR_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic [ADDR_W-1:0] head;
    logic [LEN_W-1:0]  blen;
    logic [FRAG_W-1:0] frags;
    logic [LEN_W-1:0]  plen;
  } stim_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   st;
    logic [ADDR_W-1:0]     addr;
    logic [SLOT_OUT_W-1:0] slot;
    logic [LEN_W-1:0]      olen;
  } result_t;

  typedef struct packed {
    logic    cfg_on;
    stim_t   item;
    logic    pinned;
    result_t want;
  } stim_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] mask;
    logic              en;
    logic [1:0]        base_mode;
    logic [11:0]       items;
    logic [6:0]        alloc_pct;
  } phase_plan_t;

  // Rows with cfg_on set run with the window at DIR_BASE and remapping enabled.
  localparam int DIRECTED_ROWS = 22;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b0, '{FUNC_ALLOC, ALL_ONES, 16'd0, 5'd0, 16'd0},
      1'b1, '{STATUS_PASS, ALL_ONES, 6'd0, 16'd0}},
    '{1'b0, '{FUNC_RELEASE, 64'h0, 16'd0, 5'd0, 16'd0},
      1'b1, '{STATUS_PASS, 64'h0, 6'd0, 16'd0}},
    '{1'b0, '{FUNC_OFFLOAD, 64'h7FF, 16'd0, 5'd0, 16'hFFFF},
      1'b1, '{STATUS_PASS, 64'h7FF, 6'd0, 16'd0}},
    '{1'b0, '{FUNC_UNUSED, 64'h5555_5555_5555_5555, 16'hFFFF, 5'd31, 16'hFFFF},
      1'b1, '{STATUS_PASS, 64'h5555_5555_5555_5555, 6'd0, 16'd0}},
    '{1'b1, '{FUNC_ALLOC, 64'h0, 16'd2048, 5'd0, 16'd0},
      1'b1, '{STATUS_DONE, 64'h0000_0080_0000_0800, 6'd1, 16'd0}},
    '{1'b1, '{FUNC_ALLOC, ALL_ONES, 16'd0, 5'd0, 16'd0},
      1'b0, '0},
    '{1'b1, '{FUNC_ALLOC, 64'hAAAA_AAAA_AAAA_AAAA, 16'd2049, 5'd0, 16'd0},
      1'b1, '{STATUS_PASS, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0, 16'd0}},
    '{1'b1, '{FUNC_ALLOC, 64'h1, 16'd0, 5'd1, 16'd0},
      1'b1, '{STATUS_PASS, 64'h1, 6'd0, 16'd0}},
    '{1'b1, '{FUNC_ALLOC, 64'h2, 16'hFFFF, 5'd31, 16'd0},
      1'b1, '{STATUS_PASS, 64'h2, 6'd0, 16'd0}},
    '{1'b1, '{FUNC_RELEASE, 64'h0000_0080_0000_0FFF, 16'd0, 5'd0, 16'd0},
      1'b0, '0},
    '{1'b1, '{FUNC_RELEASE, 64'h0000_0080_0000_0800, 16'd0, 5'd0, 16'd0},
      1'b1, '{STATUS_PASS, 64'h0000_0080_0000_0800, 6'd0, 16'd0}},
    '{1'b1, '{FUNC_RELEASE, 64'h0000_0080_0000_1000, 16'd0, 5'd0, 16'd0},
      1'b0, '0},
    '{1'b1, '{FUNC_RELEASE, 64'h0000_0080_0002_0000, 16'd0, 5'd0, 16'd0},
      1'b1, '{STATUS_PASS, 64'h0000_0080_0002_0000, 6'd0, 16'd0}},
    '{1'b1, '{FUNC_RELEASE, 64'h1234_0000_0000_1000, 16'd0, 5'd0, 16'd0},
      1'b1, '{STATUS_PASS, 64'h1234_0000_0000_1000, 6'd0, 16'd0}},
    '{1'b1, '{FUNC_OFFLOAD, DIR_BASE, 16'd0, 5'd0, 16'hFFFF},
      1'b1, '{STATUS_DONE, DIR_BASE, 6'd0, 16'hFFFF}},
    '{1'b1, '{FUNC_OFFLOAD, 64'h0000_0080_0001_FFFF, 16'd0, 5'd0, 16'd1},
      1'b1, '{STATUS_DONE, 64'h0000_0080_0001_FFFF, 6'd63, 16'd1}},
    '{1'b1, '{FUNC_OFFLOAD, 64'h0000_0080_0002_0000, 16'd0, 5'd0, 16'd5},
      1'b1, '{STATUS_PASS, 64'h0000_0080_0002_0000, 6'd0, 16'd0}},
    '{1'b1, '{FUNC_OFFLOAD, 64'h0, 16'd0, 5'd0, 16'd9},
      1'b1, '{STATUS_PASS, 64'h0, 6'd0, 16'd0}},
    '{1'b1, '{FUNC_UNUSED, 64'h0000_0080_0000_0800, 16'd0, 5'd0, 16'd7},
      1'b1, '{STATUS_PASS, 64'h0000_0080_0000_0800, 6'd0, 16'd0}},
    '{1'b1, '{FUNC_ALLOC, 64'h0123_4567_89AB_CDEF, 16'd1, 5'd0, 16'd0},
      1'b0, '0},
    '{1'b1, '{FUNC_RELEASE, 64'h0000_007F_FFFF_FFFF, 16'd0, 5'd0, 16'd0},
      1'b1, '{STATUS_PASS, 64'h0000_007F_FFFF_FFFF, 6'd0, 16'd0}},
    '{1'b1, '{FUNC_ALLOC, 64'h8000_0000_0000_0000, 16'd2048, 5'd0, 16'd0},
      1'b0, '0}
  };

  // A base_mode of 1 draws a random aligned base, 2 a random base and mask.
  localparam int PLAN_LEN = 8;
  localparam phase_plan_t RANDOM_PLAN [PLAN_LEN] = '{
    '{DIR_BASE, DIR_MASK, 1'b1, 2'd0, 12'd300, 7'd70},
    '{TOP_BASE, 64'h0,    1'b1, 2'd0, 12'd250, 7'd45},
    '{64'h0,    DIR_MASK, 1'b1, 2'd1, 12'd250, 7'd40},
    '{DIR_BASE, ALL_ONES, 1'b1, 2'd0, 12'd100, 7'd45},
    '{DIR_BASE, DIR_MASK, 1'b0, 2'd0, 12'd150, 7'd45},
    '{64'h0,    64'h0,    1'b1, 2'd0, 12'd150, 7'd60},
    '{64'h0,    64'h0,    1'b1, 2'd2, 12'd150, 7'd45},
    '{DIR_BASE, DIR_MASK, 1'b1, 2'd0, 12'd250, 7'd45}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     func = FUNC_ALLOC;
  logic [ADDR_W-1:0]     head_address = '0;
  logic [LEN_W-1:0]      buffer_length = '0;
  logic [FRAG_W-1:0]     fragment_count = '0;
  logic [LEN_W-1:0]      packet_length = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [ADDR_W-1:0]     result_address;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic [LEN_W-1:0]      offload_length;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_WINDOW_BASE;
  logic [ADDR_W-1:0]     cfg_data = '0;

  logic [ADDR_W-1:0] win_base = '0;
  logic [ADDR_W-1:0] win_mask = '0;
  logic              win_enable = 1'b0;
  logic [ADDR_W-1:0] slot_owner [SLOT_COUNT];
  bit                slot_taken [SLOT_COUNT];
  int                next_fit = 1;

  result_t pending_answers [$];
  result_t pin_answer = '0;
  bit      pin_row = 1'b0;
  result_t seen_answer;
  result_t due_answer;
  result_t fresh_answer;
  int      faults = 0;
  int      quiet_cycles = 0;
  int      gap_pct = 20;
  int      stall_pct = 20;

  buffer_slot_remap_allocator #(
    .SLOT_COUNT(SLOT_COUNT),
    .SLOT_SHIFT(SLOT_SHIFT),
    .SLOT_BYTES(SLOT_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .head_address(head_address),
    .buffer_length(buffer_length),
    .fragment_count(fragment_count),
    .packet_length(packet_length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .result_address(result_address),
    .slot_index(slot_index),
    .offload_length(offload_length),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] slot_window_address(input int idx);
    return ((win_base >> SLOT_SHIFT) + ADDR_W'(idx)) << SLOT_SHIFT;
  endfunction

  function automatic bit in_window(input logic [ADDR_W-1:0] addr,
                                   output logic [ADDR_W-1:0] idx);
    idx = (addr >> SLOT_SHIFT) - (win_base >> SLOT_SHIFT);
    return ((addr & win_mask) == (win_base & win_mask)) && (idx < SLOT_COUNT);
  endfunction

  function automatic result_t predict_answer(input stim_t it);
    result_t           r;
    logic [ADDR_W-1:0] idx;
    int                p;
    int                n;
    bit                found;
    r = '{STATUS_PASS, it.head, '0, '0};
    case (it.fn)
      FUNC_ALLOC: begin
        if (win_enable && it.frags == 0 && it.blen <= SLOT_BYTES) begin
          p = next_fit;
          if (p == 0 || p >= SLOT_COUNT) p = 1;
          found = 1'b0;
          for (n = 0; n < SLOT_COUNT && !found; n++) begin
            if (!slot_taken[p]) found = 1'b1;
            else p = (p + 1 >= SLOT_COUNT) ? 1 : p + 1;
          end
          if (found) begin
            slot_owner[p] = it.head;
            slot_taken[p] = 1'b1;
            next_fit = p;
            r.st = STATUS_DONE;
            r.addr = win_base + (ADDR_W'(p) << SLOT_SHIFT);
            r.slot = SLOT_OUT_W'(p);
          end else begin
            r.st = STATUS_FULL;
          end
        end
      end
      FUNC_RELEASE: begin
        if (win_base != 0 && in_window(it.head, idx) && slot_taken[idx[5:0]]) begin
          r.st = STATUS_DONE;
          r.addr = slot_owner[idx[5:0]];
          r.slot = idx[5:0];
          slot_owner[idx[5:0]] = '0;
          slot_taken[idx[5:0]] = 1'b0;
        end
      end
      FUNC_OFFLOAD: begin
        if (win_enable && in_window(it.head, idx)) begin
          r.st = STATUS_DONE;
          r.slot = idx[5:0];
          r.olen = it.plen;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic note_fault(input string what, input result_t want, input result_t got);
    faults++;
    if (faults <= 10) begin
      $display("%s: expected status %0d address %h slot %0d length %0d", what,
               want.st, want.addr, want.slot, want.olen);
      $display("  got status %0d address %h slot %0d length %0d",
               got.st, got.addr, got.slot, got.olen);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen_answer = '{status, result_address, slot_index, offload_length};
        if (pending_answers.size() == 0) begin
          note_fault("Unexpected transaction", '0, seen_answer);
        end else begin
          due_answer = pending_answers.pop_front();
          if (seen_answer.st !== due_answer.st || seen_answer.addr !== due_answer.addr ||
              seen_answer.slot !== due_answer.slot || seen_answer.olen !== due_answer.olen) begin
            note_fault("Mismatch", due_answer, seen_answer);
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh_answer = predict_answer('{func, head_address, buffer_length,
                                        fragment_count, packet_length});
        pending_answers.push_back(pin_row ? pin_answer : fresh_answer);
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_WINDOW_BASE:    win_base = cfg_data;
          CFG_WINDOW_MASK:    win_mask = cfg_data;
          CFG_OFFLOAD_ENABLE: win_enable = cfg_data[0];
          default: begin
          end
        endcase
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  task automatic offer(input stim_t it, input bit pinned, input result_t pin, input bit hold);
    if (hold) begin
      in_valid = 1'b0;
      while (pending_answers.size() != 0) @(negedge clk);
    end
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    func = it.fn;
    head_address = it.head;
    buffer_length = it.blen;
    fragment_count = it.frags;
    packet_length = it.plen;
    pin_row = pinned;
    pin_answer = pin;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] mask,
                                input logic en);
    cfg_write = 1'b1;
    cfg_index = CFG_WINDOW_BASE;
    cfg_data = base;
    @(negedge clk);
    cfg_index = CFG_WINDOW_MASK;
    cfg_data = mask;
    @(negedge clk);
    cfg_index = CFG_OFFLOAD_ENABLE;
    cfg_data = ADDR_W'(en);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic make_random_item(input int alloc_pct, output stim_t it);
    int pick;
    int idx;
    int start;
    int n;
    int release_top;
    bit hit;
    it.fn = FUNC_ALLOC;
    it.head = {$urandom, $urandom};
    it.blen = LEN_W'($urandom_range(0, 65535));
    it.frags = FRAG_W'($urandom_range(0, 31));
    it.plen = LEN_W'($urandom_range(0, 65535));
    release_top = alloc_pct + (95 - alloc_pct) * 2 / 3;
    pick = $urandom_range(1, 100);
    if (pick <= alloc_pct) begin
      if ($urandom_range(1, 4) != 1) begin
        it.frags = '0;
        it.blen = LEN_W'($urandom_range(0, SLOT_BYTES));
        if ($urandom_range(1, 8) == 1) it.blen = LEN_W'(SLOT_BYTES);
      end
    end else if (pick <= release_top) begin
      it.fn = FUNC_RELEASE;
      idx = $urandom_range(0, SLOT_COUNT - 1);
      if ($urandom_range(1, 10) <= 7) begin
        start = idx;
        hit = 1'b0;
        for (n = 0; n < SLOT_COUNT; n++) begin
          if (!hit && slot_taken[(start + n) % SLOT_COUNT]) begin
            idx = (start + n) % SLOT_COUNT;
            hit = 1'b1;
          end
        end
      end
      if ($urandom_range(1, 10) != 1)
        it.head = slot_window_address(idx) | ADDR_W'($urandom_range(0, SLOT_BYTES - 1));
    end else if (pick <= 95) begin
      it.fn = FUNC_OFFLOAD;
      idx = $urandom_range(0, SLOT_COUNT - 1);
      if ($urandom_range(1, 8) != 1)
        it.head = slot_window_address(idx) | ADDR_W'($urandom_range(0, SLOT_BYTES - 1));
    end else if (pick <= 97) begin
      it.fn = FUNC_UNUSED;
    end else begin
      it.fn = FUNC_W'($urandom_range(0, 3));
    end
  endtask

  initial begin
    phase_plan_t       plan;
    stim_t             it;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] mask;
    bit                directed_settings;
    bit                last;
    int                r;
    int                ph;
    int                k;
    directed_settings = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    for (r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].cfg_on && !directed_settings) begin
        drain();
        apply_settings(DIR_BASE, DIR_MASK, 1'b1);
        directed_settings = 1'b1;
      end
      offer(DIRECTED[r].item, DIRECTED[r].pinned, DIRECTED[r].want, 1'b0);
    end

    for (ph = 0; ph < PLAN_LEN; ph++) begin
      plan = RANDOM_PLAN[ph];
      base = plan.base;
      mask = plan.mask;
      if (plan.base_mode == 2'd1) begin
        base = {$urandom, $urandom} & DIR_MASK;
      end else if (plan.base_mode == 2'd2) begin
        base = {$urandom, $urandom};
        mask = {$urandom, $urandom};
      end
      drain();
      last = (ph == PLAN_LEN - 1);
      gap_pct = last ? 0 : ((ph % 2 == 0) ? 30 : 0);
      stall_pct = last ? 0 : ((ph % 3 == 2) ? 0 : 25);
      apply_settings(base, mask, plan.en);
      for (k = 0; k < plan.items; k++) begin
        make_random_item(plan.alloc_pct, it);
        offer(it, 1'b0, '0, $urandom_range(1, 200) == 1);
      end
    end

    drain();
    if (faults == 0 && pending_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bsra_pkg.sv
hw/rtl/bsra_table_mem.sv
hw/rtl/bsra_slot_search.sv
hw/rtl/buffer_slot_remap_allocator.sv
sim/tb_buffer_slot_remap_allocator.sv
